[rtl/dwu_pkg.sv]
// ----------------------------------------------------------------------------
// dwu_pkg
// Shared widths, codes and types of the debug watchpoint unit.
// ----------------------------------------------------------------------------
package dwu_pkg;

    localparam int MATCH_COUNT  = 8;
    localparam int WATCH_COUNT  = 10;
    localparam int COUNTER_BITS = 16;

    localparam int VALUE_W    = 32;
    localparam int ACTION_W   = 3;
    localparam int CTRL_W     = 8;
    localparam int CHAIN_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int CNT_OUT_W  = 16;
    localparam int CMP_REGS   = MATCH_COUNT / 2;
    localparam int CHAIN_REG_W = WATCH_COUNT * CHAIN_W;

    // watch control register layout
    localparam int WC_CNT_EN_LSB = 0;
    localparam int WC_SEL_LSB    = 2;
    localparam int WC_BRK_LSB    = WC_SEL_LSB + MATCH_COUNT;
    localparam int WC_TGT0_LSB   = WC_BRK_LSB + WATCH_COUNT;
    localparam int WC_TGT1_LSB   = WC_TGT0_LSB + CNT_OUT_W;
    localparam int WC_USED_W     = WC_TGT1_LSB + CNT_OUT_W;

    // result transaction layout on m_tdata
    localparam int OUT_BITS  = 1 + 2 * WATCH_COUNT + 2 * CNT_OUT_W;
    localparam int M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    // event kinds
    localparam logic [ACTION_W-1:0] ACT_FETCH_ADDR = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_ADDR  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_STORE_ADDR = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_LOAD_DATA  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_STORE_DATA = 3'd4;

    // matchpoint compare types
    localparam logic [2:0] CT_NONE       = 3'd0;
    localparam logic [2:0] CT_FETCH_ADDR = 3'd1;
    localparam logic [2:0] CT_LOAD_ADDR  = 3'd2;
    localparam logic [2:0] CT_STORE_ADDR = 3'd3;
    localparam logic [2:0] CT_LOAD_DATA  = 3'd4;
    localparam logic [2:0] CT_STORE_DATA = 3'd5;
    localparam logic [2:0] CT_LS_ADDR    = 3'd6;
    localparam logic [2:0] CT_LS_DATA    = 3'd7;

    // matchpoint conditions
    localparam logic [2:0] COND_MASKED = 3'd0;
    localparam logic [2:0] COND_EQ     = 3'd1;
    localparam logic [2:0] COND_LT     = 3'd2;
    localparam logic [2:0] COND_LE     = 3'd3;
    localparam logic [2:0] COND_GT     = 3'd4;
    localparam logic [2:0] COND_GE     = 3'd5;
    localparam logic [2:0] COND_NE     = 3'd6;
    localparam logic [2:0] COND_RSVD   = 3'd7;

    // watchpoint chain modes
    localparam logic [CHAIN_W-1:0] CHAIN_ALONE = 2'd0;
    localparam logic [CHAIN_W-1:0] CHAIN_AND   = 2'd1;
    localparam logic [CHAIN_W-1:0] CHAIN_OR    = 2'd2;
    localparam logic [CHAIN_W-1:0] CHAIN_RSVD  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_UNIT_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_CTRL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CMP_01      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CMP_23      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CMP_45      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CMP_67      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CHAIN       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_WATCH_CTRL  = 3'd7;

    typedef struct packed {
        logic                                  unit_enable;
        logic [MATCH_COUNT-1:0][CTRL_W-1:0]    match_ctrl;
        logic [MATCH_COUNT-1:0][VALUE_W-1:0]   cmp_val;
        logic [WATCH_COUNT-1:0][CHAIN_W-1:0]   chain_mode;
        logic [1:0]                            cnt_en;
        logic [MATCH_COUNT-1:0]                cnt_sel;
        logic [WATCH_COUNT-1:0]                brk_en;
        logic [COUNTER_BITS-1:0]               target0;
        logic [COUNTER_BITS-1:0]               target1;
    } cfg_t;

    typedef struct packed {
        logic                   break_hit;
        logic [WATCH_COUNT-1:0] watch_hits;
        logic [WATCH_COUNT-1:0] break_status;
        logic [CNT_OUT_W-1:0]   count_zero;
        logic [CNT_OUT_W-1:0]   count_one;
    } result_t;

endpackage

[rtl/dwu_regs.sv]
// ----------------------------------------------------------------------------
// dwu_regs
// Configuration register file: write-only port, decoded into a struct.
// ----------------------------------------------------------------------------
module dwu_regs import dwu_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    logic                                unit_enable_reg;
    logic [CFG_DATA_W-1:0]               match_ctrl_reg;
    logic [CMP_REGS-1:0][CFG_DATA_W-1:0] cmp_val_reg;
    logic [CHAIN_REG_W-1:0]              chain_reg;
    logic [WC_USED_W-1:0]                watch_reg;
    logic [$clog2(CMP_REGS)-1:0]         cmp_idx;

    assign cmp_idx = $clog2(CMP_REGS)'(cfg_addr - REG_CMP_01);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_enable_reg <= 1'b0;
            match_ctrl_reg  <= '0;
            cmp_val_reg     <= '0;
            chain_reg       <= '0;
            watch_reg       <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_UNIT_ENABLE: begin
                    unit_enable_reg <= cfg_wdata[0];
                end
                REG_MATCH_CTRL: begin
                    match_ctrl_reg <= cfg_wdata;
                end
                REG_CMP_01, REG_CMP_23, REG_CMP_45, REG_CMP_67: begin
                    cmp_val_reg[cmp_idx] <= cfg_wdata;
                end
                REG_CHAIN: begin
                    chain_reg <= cfg_wdata[CHAIN_REG_W-1:0];
                end
                REG_WATCH_CTRL: begin
                    watch_reg <= cfg_wdata[WC_USED_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        cfg.unit_enable = unit_enable_reg;
        cfg.match_ctrl  = match_ctrl_reg;
        for (int i = 0; i < MATCH_COUNT; i++) begin
            // even matchpoint in the low half, odd one in the high half
            cfg.cmp_val[i] = cmp_val_reg[i / 2][(i % 2) * VALUE_W +: VALUE_W];
        end
        cfg.chain_mode = chain_reg;
        cfg.cnt_en     = watch_reg[WC_CNT_EN_LSB +: 2];
        cfg.cnt_sel    = watch_reg[WC_SEL_LSB +: MATCH_COUNT];
        cfg.brk_en     = watch_reg[WC_BRK_LSB +: WATCH_COUNT];
        cfg.target0    = watch_reg[WC_TGT0_LSB +: COUNTER_BITS];
        cfg.target1    = watch_reg[WC_TGT1_LSB +: COUNTER_BITS];
    end

endmodule

[rtl/dwu_match.sv]
// ----------------------------------------------------------------------------
// dwu_match
// Eight matchpoints: event kind filter and value compare, all in parallel.
// ----------------------------------------------------------------------------
module dwu_match import dwu_pkg::*; (
    input  cfg_t                   cfg,
    input  logic [ACTION_W-1:0]    action,
    input  logic [VALUE_W-1:0]     event_value,
    output logic [MATCH_COUNT-1:0] mp_hit
);

    function automatic logic type_fits(input logic [2:0] ctype,
                                       input logic [ACTION_W-1:0] act);
        logic fit;
        case (ctype)
            CT_FETCH_ADDR: fit = (act == ACT_FETCH_ADDR);
            CT_LOAD_ADDR:  fit = (act == ACT_LOAD_ADDR);
            CT_STORE_ADDR: fit = (act == ACT_STORE_ADDR);
            CT_LOAD_DATA:  fit = (act == ACT_LOAD_DATA);
            CT_STORE_DATA: fit = (act == ACT_STORE_DATA);
            CT_LS_ADDR:    fit = (act inside {ACT_LOAD_ADDR, ACT_STORE_ADDR});
            CT_LS_DATA:    fit = (act inside {ACT_LOAD_DATA, ACT_STORE_DATA});
            default:       fit = 1'b0;
        endcase
        return fit;
    endfunction

    function automatic logic value_cmp(input logic [2:0] cond, input logic sgn,
                                       input logic [VALUE_W-1:0] a,
                                       input logic [VALUE_W-1:0] b);
        logic [VALUE_W-1:0] x;
        logic [VALUE_W-1:0] y;
        logic               res;
        // flipping the sign bit turns a signed order into an unsigned one
        x = {a[VALUE_W-1] ^ sgn, a[VALUE_W-2:0]};
        y = {b[VALUE_W-1] ^ sgn, b[VALUE_W-2:0]};
        case (cond)
            COND_MASKED: res = |(a & b);
            COND_EQ:     res = (a == b);
            COND_LT:     res = (x < y);
            COND_LE:     res = (x <= y);
            COND_GT:     res = (x > y);
            COND_GE:     res = (x >= y);
            COND_NE:     res = (a != b);
            default:     res = 1'b0;
        endcase
        return res;
    endfunction

    always_comb begin
        for (int i = 0; i < MATCH_COUNT; i++) begin
            // control byte: present, type 3b, signed, condition 3b
            mp_hit[i] = cfg.match_ctrl[i][0]
                      && type_fits(cfg.match_ctrl[i][3:1], action)
                      && value_cmp(cfg.match_ctrl[i][7:5], cfg.match_ctrl[i][4],
                                   event_value, cfg.cmp_val[i]);
        end
    end

endmodule

[rtl/dwu_watch.sv]
// ----------------------------------------------------------------------------
// dwu_watch
// Watchpoint chaining, hit counters and sticky break status.
// ----------------------------------------------------------------------------
module dwu_watch import dwu_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step,
    input  cfg_t                   cfg,
    input  logic [MATCH_COUNT-1:0] mp_hit,
    output result_t                res
);

    localparam int INC_W = $clog2(MATCH_COUNT + 1);
    localparam int SUM_W = COUNTER_BITS + INC_W;

    logic [COUNTER_BITS-1:0] counter_zero_reg, counter_zero_next;
    logic [COUNTER_BITS-1:0] counter_one_reg, counter_one_next;
    logic [WATCH_COUNT-1:0]  status_reg, status_next;

    logic                   active;
    logic [WATCH_COUNT-1:0] wp;
    logic [INC_W-1:0]       inc0, inc1;
    logic [SUM_W-1:0]       sum0, sum1;
    logic [WATCH_COUNT-1:0] hits;
    logic [WATCH_COUNT-1:0] brk_bits;

    function automatic logic chain_fn(input logic [CHAIN_W-1:0] mode,
                                      input logic first, input logic own,
                                      input logic prev);
        logic r;
        case (mode)
            CHAIN_ALONE: r = own;
            CHAIN_AND:   r = !first && own && prev;
            CHAIN_OR:    r = !first && (own || prev);
            default:     r = 1'b0;
        endcase
        return r;
    endfunction

    always_comb begin
        active = cfg.unit_enable && (|{cfg.brk_en, cfg.cnt_sel}) && (|mp_hit);

        wp = '0;
        for (int w = 0; w < MATCH_COUNT; w++) begin
            // watchpoint 0 has no predecessor to chain with
            wp[w] = chain_fn(cfg.chain_mode[w], w == 0, mp_hit[w],
                             (w == 0) ? 1'b0 : wp[(w == 0) ? 0 : w - 1]);
        end

        inc0 = '0;
        inc1 = '0;
        for (int w = 0; w < MATCH_COUNT; w++) begin
            inc0 = inc0 + INC_W'(wp[w] && !cfg.cnt_sel[w]);
            inc1 = inc1 + INC_W'(wp[w] && cfg.cnt_sel[w]);
        end
        sum0 = SUM_W'(counter_zero_reg) + SUM_W'(inc0);
        sum1 = SUM_W'(counter_one_reg) + SUM_W'(inc1);

        counter_zero_next = (active && cfg.cnt_en[0]) ? sum0[COUNTER_BITS-1:0]
                                                      : counter_zero_reg;
        counter_one_next  = (active && cfg.cnt_en[1]) ? sum1[COUNTER_BITS-1:0]
                                                      : counter_one_reg;

        // counter watchpoints see the counts after this event
        wp[MATCH_COUNT]     = chain_fn(cfg.chain_mode[MATCH_COUNT], 1'b0,
                                       counter_zero_next == cfg.target0,
                                       wp[MATCH_COUNT-1]);
        wp[MATCH_COUNT + 1] = chain_fn(cfg.chain_mode[MATCH_COUNT + 1], 1'b0,
                                       counter_one_next == cfg.target1,
                                       wp[MATCH_COUNT]);

        hits        = active ? wp : '0;
        brk_bits    = hits & cfg.brk_en;
        status_next = status_reg | brk_bits;

        res.break_hit    = |brk_bits;
        res.watch_hits   = hits;
        res.break_status = status_next;
        res.count_zero   = CNT_OUT_W'(counter_zero_next);
        res.count_one    = CNT_OUT_W'(counter_one_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            counter_zero_reg <= '0;
            counter_one_reg  <= '0;
            status_reg       <= '0;
        end else if (step) begin
            counter_zero_reg <= counter_zero_next;
            counter_one_reg  <= counter_one_next;
            status_reg       <= status_next;
        end
    end

endmodule

[rtl/debug_watchpoint_unit.sv]
// ----------------------------------------------------------------------------
// debug_watchpoint_unit
// Eight matchpoints feeding ten chained watchpoints, two hit counters and
// sticky break status, one result per processor event.
//
//  channel  | ports          | transaction
//  ---------+----------------+------------------------------------------------
//  event in | s_t*           | tuser: action[2:0]; tdata: event_value[31:0]
//  result   | m_t*           | break_hit, watch_hits, break_status, counts
//  config   | cfg_*          | write enable, register index, 64-bit data
//
// one event per cycle sustained while the result is not stalled; an accepted
// event passes the input register, then match/chain/count logic into the
// result register. the counter and status update is the loop setting the rate.
// reset (aresetn low, synchronous) clears config, counters, status and valids.
// a stalled result holds both stages; the input stage still takes an event
// while the result register waits, so ready drops only when both are full.
// ----------------------------------------------------------------------------
module debug_watchpoint_unit import dwu_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [VALUE_W-1:0]    s_tdata,   // event_value[31:0]
    input  logic [ACTION_W-1:0]   s_tuser,   // action[2:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // break_hit[0], watch_hits[10:1], break_status[20:11],
    // count_zero[36:21], count_one[52:37], zero pad above
    output logic [M_TDATA_W-1:0]  m_tdata
);

    cfg_t                   cfg;
    result_t                res;
    logic [MATCH_COUNT-1:0] mp_hit;

    logic                   in_valid_reg;
    logic [ACTION_W-1:0]    action_reg;
    logic [VALUE_W-1:0]     value_reg;
    logic                   out_valid_reg;
    logic [M_TDATA_W-1:0]   out_data_reg;
    logic                   advance;
    logic                   step;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign step     = in_valid_reg && advance;

    dwu_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    dwu_match u_match (
        .cfg         (cfg),
        .action      (action_reg),
        .event_value (value_reg),
        .mp_hit      (mp_hit)
    );

    dwu_watch u_watch (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .cfg     (cfg),
        .mp_hit  (mp_hit),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            action_reg <= s_tuser;
            value_reg  <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            out_data_reg <= M_TDATA_W'({res.count_one, res.count_zero,
                                        res.break_status, res.watch_hits,
                                        res.break_hit});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

[rtl/dwu_checker.sv]
// ----------------------------------------------------------------------------
// dwu_checker
// Port-level checks of the debug watchpoint unit, bound to the top level.
// ----------------------------------------------------------------------------
module dwu_checker import dwu_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [M_TDATA_W-1:0]  m_tdata
);

    // a stalled result keeps its transaction
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // reset empties the result register
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // with nothing in the result register the input side is never held off
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled while result register is empty");

    // a break needs a hit whose sticky status bit is set
    a_break: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> (m_tdata[10:1] & m_tdata[20:11]) != '0)
        else $error("break without a matching status bit");

endmodule

bind debug_watchpoint_unit dwu_checker u_dwu_checker (.*);

[sim/tb_debug_watchpoint_unit.sv]
// ----------------------------------------------------------------------------
// tb_debug_watchpoint_unit
// Self-checking bench for the debug watchpoint unit. Processor events are
// streamed in with random gaps. A class keeps its own copy of the matchpoint,
// chain, counter and break status logic and checks every result field. The
// configuration is rewritten between phases while the unit is idle. A
// back-to-back fetch run hits every matchpoint on each event.
// ----------------------------------------------------------------------------
module tb_debug_watchpoint_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import dwu_pkg::*;

    localparam int STALL_LIMIT   = 1000;
    localparam int PHASE_ITEMS   = 60;
    localparam int PHASES_A      = 8;
    localparam int PHASES_B      = 6;
    localparam int WRAP_ITEMS    = 60;

    // actions with no meaning to any matchpoint
    localparam logic [ACTION_W-1:0] ACT_RSVD_A = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_RSVD_B = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_RSVD_C = 3'd7;

    class watch_event_scoreboard;
        bit                          unit_on;
        bit [CFG_DATA_W-1:0]         match_ctl;
        bit [VALUE_W-1:0]            cmp_val [MATCH_COUNT];
        bit [CHAIN_REG_W-1:0]        chain_ctl;
        bit [CFG_DATA_W-1:0]         watch_ctl;
        bit [COUNTER_BITS-1:0]       cnt0;
        bit [COUNTER_BITS-1:0]       cnt1;
        bit [WATCH_COUNT-1:0]        sticky;
        result_t                     due_reports[$];
        int                          errors;
        int                          shown;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            int k;
            case (idx)
                REG_UNIT_ENABLE: unit_on = d[0];
                REG_MATCH_CTRL:  match_ctl = d;
                REG_CMP_01, REG_CMP_23, REG_CMP_45, REG_CMP_67: begin
                    k = int'(idx - REG_CMP_01);
                    cmp_val[2*k]   = d[31:0];
                    cmp_val[2*k+1] = d[63:32];
                end
                REG_CHAIN:       chain_ctl = d[CHAIN_REG_W-1:0];
                REG_WATCH_CTRL:  watch_ctl = d;
                default: ;
            endcase
        endfunction

        function bit kind_fits(bit [2:0] ct, bit [ACTION_W-1:0] act);
            case (ct)
                CT_FETCH_ADDR: return act == ACT_FETCH_ADDR;
                CT_LOAD_ADDR:  return act == ACT_LOAD_ADDR;
                CT_STORE_ADDR: return act == ACT_STORE_ADDR;
                CT_LOAD_DATA:  return act == ACT_LOAD_DATA;
                CT_STORE_DATA: return act == ACT_STORE_DATA;
                CT_LS_ADDR:    return act == ACT_LOAD_ADDR || act == ACT_STORE_ADDR;
                CT_LS_DATA:    return act == ACT_LOAD_DATA || act == ACT_STORE_DATA;
                default:       return 1'b0;
            endcase
        endfunction

        function bit cond_holds(bit [2:0] cond, bit sgn, bit [VALUE_W-1:0] a,
                                bit [VALUE_W-1:0] b);
            bit [VALUE_W-1:0] x;
            bit [VALUE_W-1:0] y;
            // sign flip maps signed order onto unsigned order
            x = sgn ? (a ^ 32'h8000_0000) : a;
            y = sgn ? (b ^ 32'h8000_0000) : b;
            case (cond)
                COND_MASKED: return (a & b) != '0;
                COND_EQ:     return a == b;
                COND_LT:     return x < y;
                COND_LE:     return x <= y;
                COND_GT:     return x > y;
                COND_GE:     return x >= y;
                COND_NE:     return a != b;
                default:     return 1'b0;
            endcase
        endfunction

        function bit link(int w, bit own, bit prev);
            bit [CHAIN_W-1:0] mode;
            mode = chain_ctl[CHAIN_W*w +: CHAIN_W];
            if (mode == CHAIN_ALONE) return own;
            // watchpoint 0 would chain an external input that is absent
            if (w == 0 || mode == CHAIN_RSVD) return 1'b0;
            if (mode == CHAIN_AND) return own && prev;
            return own || prev;
        endfunction

        function void note_event(bit [ACTION_W-1:0] act, bit [VALUE_W-1:0] val);
            result_t              r;
            bit [CTRL_W-1:0]      ctl;
            bit [MATCH_COUNT-1:0] mp;
            bit [WATCH_COUNT-1:0] wp;
            bit [WATCH_COUNT-1:0] brk_en;
            bit [MATCH_COUNT-1:0] sel;
            bit                   prev;
            brk_en = watch_ctl[WC_BRK_LSB +: WATCH_COUNT];
            sel    = watch_ctl[WC_SEL_LSB +: MATCH_COUNT];
            mp = '0;
            wp = '0;
            if (unit_on && (brk_en != '0 || sel != '0)) begin
                for (int i = 0; i < MATCH_COUNT; i++) begin
                    ctl = match_ctl[CTRL_W*i +: CTRL_W];
                    if (ctl[0] && kind_fits(ctl[3:1], act))
                        mp[i] = cond_holds(ctl[7:5], ctl[4], val, cmp_val[i]);
                end
                if (mp != '0) begin
                    prev = 1'b0;
                    for (int w = 0; w < MATCH_COUNT; w++) begin
                        wp[w] = link(w, mp[w], prev);
                        prev  = wp[w];
                    end
                    for (int w = 0; w < MATCH_COUNT; w++) begin
                        if (wp[w]) begin
                            if (!sel[w]) begin
                                if (watch_ctl[WC_CNT_EN_LSB]) cnt0 = cnt0 + COUNTER_BITS'(1);
                            end else begin
                                if (watch_ctl[WC_CNT_EN_LSB+1]) cnt1 = cnt1 + COUNTER_BITS'(1);
                            end
                        end
                    end
                    wp[8] = link(8, cnt0 == watch_ctl[WC_TGT0_LSB +: COUNTER_BITS], wp[7]);
                    wp[9] = link(9, cnt1 == watch_ctl[WC_TGT1_LSB +: COUNTER_BITS], wp[8]);
                    sticky |= wp & brk_en;
                end
            end
            r.break_hit    = |(wp & brk_en);
            r.watch_hits   = wp;
            r.break_status = sticky;
            r.count_zero   = cnt0;
            r.count_one    = cnt1;
            due_reports.push_back(r);
        endfunction

        function void field_diff(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                if (shown < 64)
                    $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
                shown++;
            end
        endfunction

        function void check_report(logic [M_TDATA_W-1:0] d);
            result_t want;
            if (due_reports.size() == 0) begin
                errors++;
                if (shown < 64)
                    $display("%0t: unexpected result: expected none, got %0h", $time, d);
                shown++;
                return;
            end
            want = due_reports.pop_front();
            field_diff("break_hit", 32'(want.break_hit), 32'(d[0]));
            field_diff("watch_hits", 32'(want.watch_hits), 32'(d[1 +: WATCH_COUNT]));
            field_diff("break_status", 32'(want.break_status),
                       32'(d[1+WATCH_COUNT +: WATCH_COUNT]));
            field_diff("count_zero", 32'(want.count_zero),
                       32'(d[1+2*WATCH_COUNT +: CNT_OUT_W]));
            field_diff("count_one", 32'(want.count_one),
                       32'(d[1+2*WATCH_COUNT+CNT_OUT_W +: CNT_OUT_W]));
        endfunction
    endclass

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [VALUE_W-1:0]    s_tdata   = '0;   // event_value[31:0]
    logic [ACTION_W-1:0]   s_tuser   = '0;   // action[2:0]
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // break_hit[0], watch_hits[10:1], break_status[20:11],
    // count_zero[36:21], count_one[52:37]
    logic [M_TDATA_W-1:0]  m_tdata;

    watch_event_scoreboard sb;
    bit                    steady = 1'b0;

    debug_watchpoint_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic bit [CTRL_W-1:0] mp_ctl(bit present, bit [2:0] ct, bit sgn,
                                               bit [2:0] cond);
        return {cond, sgn, ct, present};
    endfunction

    function automatic bit [VALUE_W-1:0] edge_value();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= d;
        @(posedge aclk);
        sb.write_reg(idx, d);
    endtask

    task automatic apply_config(input bit en, input bit [CFG_DATA_W-1:0] mctl,
                                input bit [VALUE_W-1:0] cv [MATCH_COUNT],
                                input bit [CHAIN_REG_W-1:0] chain,
                                input bit [CFG_DATA_W-1:0] wctl);
        bit [CFG_DATA_W-1:0] noise;
        noise = {$urandom, $urandom};
        cfg_write(REG_UNIT_ENABLE, {noise[63:1], en});
        cfg_write(REG_MATCH_CTRL, mctl);
        for (int k = 0; k < CMP_REGS; k++)
            cfg_write(REG_CMP_01 + CFG_IDX_W'(k), {cv[2*k+1], cv[2*k]});
        cfg_write(REG_CHAIN, {noise[63:CHAIN_REG_W], chain});
        cfg_write(REG_WATCH_CTRL, wctl);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // valid stays high after acceptance so back-to-back events need no toggle
    task automatic send_event(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] val,
                              input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= val;
        do @(posedge aclk); while (!s_tready);
        sb.note_event(act, val);
    endtask

    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (sb.due_reports.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic random_phase(input int n_items);
        bit                    en;
        bit [CFG_DATA_W-1:0]   mctl;
        bit [VALUE_W-1:0]      cv [MATCH_COUNT];
        bit [CHAIN_REG_W-1:0]  chain;
        bit [CFG_DATA_W-1:0]   wctl;
        bit [ACTION_W-1:0]     act;
        bit [VALUE_W-1:0]      val;
        int                    r;
        en = ($urandom_range(0, 9) != 0);
        for (int i = 0; i < MATCH_COUNT; i++) begin
            mctl[CTRL_W*i +: CTRL_W] = mp_ctl($urandom_range(0, 9) != 0,
                                              3'($urandom_range(0, 7)),
                                              1'($urandom_range(0, 1)),
                                              3'($urandom_range(0, 7)));
            cv[i] = edge_value();
        end
        for (int w = 0; w < WATCH_COUNT; w++) begin
            r = $urandom_range(0, 19);
            chain[CHAIN_W*w +: CHAIN_W] = (r < 8)  ? CHAIN_ALONE :
                                          (r < 13) ? CHAIN_AND :
                                          (r < 18) ? CHAIN_OR : CHAIN_RSVD;
        end
        wctl = {$urandom, $urandom};
        // targets just ahead of the counters so the counter watchpoints fire
        if ($urandom_range(0, 3) != 0) begin
            wctl[WC_TGT0_LSB +: COUNTER_BITS] = sb.cnt0 + COUNTER_BITS'($urandom_range(0, 6));
            wctl[WC_TGT1_LSB +: COUNTER_BITS] = sb.cnt1 + COUNTER_BITS'($urandom_range(0, 6));
        end
        if ($urandom_range(0, 11) == 0) begin
            wctl[WC_SEL_LSB +: MATCH_COUNT] = '0;
            wctl[WC_BRK_LSB +: WATCH_COUNT] = '0;
        end
        apply_config(en, mctl, cv, chain, wctl);
        for (int n = 0; n < n_items; n++) begin
            act = ($urandom_range(0, 99) < 7)
                ? ACTION_W'($urandom_range(ACT_RSVD_A, ACT_RSVD_C))
                : ACTION_W'($urandom_range(ACT_FETCH_ADDR, ACT_STORE_DATA));
            r = $urandom_range(0, 99);
            if (r < 40)      val = cv[$urandom_range(0, MATCH_COUNT-1)];
            else if (r < 55) val = cv[$urandom_range(0, MATCH_COUNT-1)] + VALUE_W'(1);
            else if (r < 65) val = cv[$urandom_range(0, MATCH_COUNT-1)] - VALUE_W'(1);
            else if (r < 80) val = edge_value();
            else             val = $urandom;
            if ($urandom_range(0, 99) == 0) quiesce();
            send_event(act, val, idle_gap());
        end
        quiesce();
    endtask

    // result monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_report(m_tdata);
    end

    // result back-pressure
    initial begin
        int run;
        int gap;
        @(posedge aclk);
        forever begin
            run = $urandom_range(1, 12);
            m_tready <= 1'b1;
            repeat (run) @(posedge aclk);
            gap = idle_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("tb_debug_watchpoint_unit: FAIL");
        $finish;
    end

    initial begin
        bit [CFG_DATA_W-1:0]  mctl;
        bit [VALUE_W-1:0]     cv [MATCH_COUNT];
        bit [CHAIN_REG_W-1:0] chain;
        bit [CFG_DATA_W-1:0]  wctl;
        sb = new;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // every compare type but none (fetch on two matchpoints), every condition
        mctl[0*CTRL_W +: CTRL_W] = mp_ctl(1'b1, CT_FETCH_ADDR, 1'b0, COND_EQ);
        mctl[1*CTRL_W +: CTRL_W] = mp_ctl(1'b1, CT_LOAD_ADDR,  1'b0, COND_MASKED);
        mctl[2*CTRL_W +: CTRL_W] = mp_ctl(1'b1, CT_STORE_ADDR, 1'b1, COND_LT);
        mctl[3*CTRL_W +: CTRL_W] = mp_ctl(1'b1, CT_LOAD_DATA,  1'b0, COND_LE);
        mctl[4*CTRL_W +: CTRL_W] = mp_ctl(1'b1, CT_STORE_DATA, 1'b0, COND_GT);
        mctl[5*CTRL_W +: CTRL_W] = mp_ctl(1'b1, CT_LS_ADDR,    1'b1, COND_GE);
        mctl[6*CTRL_W +: CTRL_W] = mp_ctl(1'b1, CT_LS_DATA,    1'b0, COND_NE);
        mctl[7*CTRL_W +: CTRL_W] = mp_ctl(1'b1, CT_FETCH_ADDR, 1'b0, COND_RSVD);
        cv = '{32'h0, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000,
               32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h1234_5678, 32'h0};
        chain = '0;
        chain[CHAIN_W*8 +: CHAIN_W] = CHAIN_AND;
        chain[CHAIN_W*9 +: CHAIN_W] = CHAIN_OR;
        wctl = '0;
        wctl[WC_CNT_EN_LSB +: 2]          = 2'b11;
        wctl[WC_SEL_LSB +: MATCH_COUNT]   = 8'hAA;
        wctl[WC_BRK_LSB +: WATCH_COUNT]   = '1;
        wctl[WC_TGT0_LSB +: COUNTER_BITS] = 16'd1;
        wctl[WC_TGT1_LSB +: COUNTER_BITS] = 16'd2;
        apply_config(1'b1, mctl, cv, chain, wctl);
        send_event(ACT_FETCH_ADDR, 32'h0000_0000, 0);
        send_event(ACT_FETCH_ADDR, 32'hFFFF_FFFF, 0);
        send_event(ACT_LOAD_ADDR,  32'h0000_0000, 1);
        send_event(ACT_LOAD_ADDR,  32'hFFFF_FFFF, 0);
        send_event(ACT_STORE_ADDR, 32'h8000_0000, 0);
        send_event(ACT_STORE_ADDR, 32'h7FFF_FFFF, 2);
        send_event(ACT_LOAD_DATA,  32'h8000_0000, 0);
        send_event(ACT_LOAD_DATA,  32'hFFFF_FFFF, 0);
        send_event(ACT_STORE_DATA, 32'h8000_0000, 0);
        send_event(ACT_STORE_DATA, 32'h1234_5678, 0);
        send_event(ACT_RSVD_A,     32'h0000_0000, 0);
        send_event(ACT_RSVD_B,     32'hFFFF_FFFF, 0);
        send_event(ACT_RSVD_C,     32'h1234_5678, 0);
        quiesce();

        // external-chain modes on watchpoint 0 and the reserved mode
        chain[CHAIN_W*0 +: CHAIN_W] = CHAIN_OR;
        chain[CHAIN_W*1 +: CHAIN_W] = CHAIN_RSVD;
        chain[CHAIN_W*2 +: CHAIN_W] = CHAIN_OR;
        chain[CHAIN_W*3 +: CHAIN_W] = CHAIN_AND;
        chain[CHAIN_W*5 +: CHAIN_W] = CHAIN_AND;
        apply_config(1'b1, mctl, cv, chain, wctl);
        send_event(ACT_FETCH_ADDR, 32'h0000_0000, 0);
        send_event(ACT_LOAD_ADDR,  32'h8000_0001, 0);
        send_event(ACT_STORE_DATA, 32'hFFFF_FFFF, 0);
        quiesce();

        // unit disabled
        apply_config(1'b0, mctl, cv, chain, wctl);
        send_event(ACT_FETCH_ADDR, 32'h0000_0000, 0);
        send_event(ACT_LOAD_ADDR,  32'hFFFF_FFFF, 0);
        quiesce();

        // no break enable and no counter select
        wctl[WC_SEL_LSB +: MATCH_COUNT] = '0;
        wctl[WC_BRK_LSB +: WATCH_COUNT] = '0;
        apply_config(1'b1, mctl, cv, chain, wctl);
        send_event(ACT_FETCH_ADDR, 32'h0000_0000, 0);
        send_event(ACT_STORE_ADDR, 32'h8000_0000, 0);
        quiesce();

        for (int p = 0; p < PHASES_A; p++) random_phase(PHASE_ITEMS);

        // every fetch hits all eight matchpoints, four per counter, back to back
        for (int i = 0; i < MATCH_COUNT; i++) begin
            mctl[CTRL_W*i +: CTRL_W] = mp_ctl(1'b1, CT_FETCH_ADDR, 1'b0, COND_GE);
            cv[i] = '0;
        end
        wctl = {$urandom, $urandom};
        wctl[WC_CNT_EN_LSB +: 2]        = 2'b11;
        wctl[WC_SEL_LSB +: MATCH_COUNT] = 8'h0F;
        apply_config(1'b1, mctl, cv, '0, wctl);
        steady = 1'b1;
        for (int n = 0; n < WRAP_ITEMS; n++) send_event(ACT_FETCH_ADDR, $urandom, 0);
        steady = 1'b0;
        quiesce();

        for (int p = 0; p < PHASES_B; p++) random_phase(PHASE_ITEMS);

        quiesce();
        repeat (8) @(posedge aclk);
        if (sb.errors == 0 && sb.due_reports.size() == 0) begin
            $display("tb_debug_watchpoint_unit: PASS");
        end else begin
            $display("tb_debug_watchpoint_unit: FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/dwu_pkg.sv
rtl/dwu_regs.sv
rtl/dwu_match.sv
rtl/dwu_watch.sv
rtl/debug_watchpoint_unit.sv
rtl/dwu_checker.sv
sim/tb_debug_watchpoint_unit.sv
